// ----- rtl/ibw_pkg.sv -----
// ---------------------------------------------------------------------------
// ibw_pkg
// Shared widths, register map, stage numbers and cell types of the
// inverse bilinear weights block.
// ---------------------------------------------------------------------------
package ibw_pkg;

    // coordinate and weight formats
    localparam int COORD_W = 16;
    localparam int FRAC    = 15;
    localparam int Q_W     = FRAC + 1;
    localparam int W_W     = 16;

    // differences of corners (b, c, d need one more bit, a needs two)
    localparam int D1_W    = COORD_W + 1;
    localparam int D2_W    = COORD_W + 2;
    localparam int PROD_W  = D1_W + D2_W;
    localparam int COEF_W  = PROD_W + 3;
    localparam int MAG_W   = COEF_W - 1;

    // normalized coefficients: magnitude at most 2^30-1
    localparam int NMAG_W  = 30;
    localparam int NORM_W  = NMAG_W + 1;
    localparam int SH_W    = $clog2(MAG_W - NMAG_W + 1);
    localparam int SQP_W   = 2 * NORM_W;

    // discriminant and root
    localparam int DISC_W  = 64;
    localparam int RAD_W   = DISC_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 4;
    localparam int SQRT_STEPS = ROOT_W;

    // fraction divider
    localparam int DIV_W   = 40;
    localparam int DIVM_W  = DIV_W;
    localparam int DIV_CELLS = Q_W;
    localparam int DIV_LAT = DIV_CELLS + 2;
    localparam int VP_W    = D2_W + Q_W + 1;
    localparam int WP_W    = 2 * Q_W;

    localparam logic [Q_W-1:0]  ONE_Q = Q_W'(1) << FRAC;
    localparam logic [WP_W-1:0] HALF_Q = WP_W'(1) << (FRAC - 1);

    // register map
    localparam int CFG_AW  = 5;
    localparam int CFG_IW  = 3;
    localparam logic [CFG_IW-1:0] REG_C00X = 3'd0;
    localparam logic [CFG_IW-1:0] REG_C00Y = 3'd1;
    localparam logic [CFG_IW-1:0] REG_C01X = 3'd2;
    localparam logic [CFG_IW-1:0] REG_C01Y = 3'd3;
    localparam logic [CFG_IW-1:0] REG_C10X = 3'd4;
    localparam logic [CFG_IW-1:0] REG_C10Y = 3'd5;
    localparam logic [CFG_IW-1:0] REG_C11X = 3'd6;
    localparam logic [CFG_IW-1:0] REG_C11Y = 3'd7;

    // pipeline stage numbers (register stage that holds the value)
    localparam int ST_D     = 1;
    localparam int ST_NORM  = 5;
    localparam int ST_DISC  = 7;
    localparam int ST_SQ    = ST_DISC + SQRT_STEPS;
    localparam int ST_UNUM  = ST_SQ + 1;
    localparam int ST_U     = ST_UNUM + DIV_LAT;
    localparam int ST_VPROD = ST_U + 1;
    localparam int ST_VNUM  = ST_VPROD + 1;
    localparam int ST_V     = ST_VNUM + DIV_LAT;
    localparam int ST_SEL   = ST_V + 1;
    localparam int ST_W     = ST_SEL + 1;

    // one step of the square root chain
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_cell_t;

    // one step of the fraction divider chain
    typedef struct packed {
        logic [DIVM_W:0]   rem;
        logic [DIVM_W-1:0] den;
        logic [Q_W-1:0]    q;
        logic              neg;
        logic              ok;
    } div_cell_t;

endpackage

// ----- rtl/ibw_delay.sv -----
// ---------------------------------------------------------------------------
// ibw_delay
// Shift line that carries side data alongside the pipeline.
// ---------------------------------------------------------------------------
module ibw_delay
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
    )
    (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
    );

    logic [WIDTH-1:0] taps_reg [DEPTH];

    // shift by one stage on each pipeline advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            taps_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                taps_reg[k] <= taps_reg[k-1];
            end
        end
    end

    assign dout = taps_reg[DEPTH-1];

endmodule

// ----- rtl/ibw_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// ibw_sqrt_cell
// One root bit of the integer square root: takes two radicand bits.
// ---------------------------------------------------------------------------
module ibw_sqrt_cell
    import ibw_pkg::*;
    (
    input  logic       clk,
    input  logic       en,
    input  sqrt_cell_t cell_in,
    output sqrt_cell_t cell_out
    );

    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    sqrt_cell_t       cell_next;
    sqrt_cell_t       cell_reg;

    // bring down two bits and try the next root bit
    always_comb
    begin
        acc   = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1 -: 2]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, cell_in.root, 2'b01};
        cell_next.rad = {cell_in.rad[RAD_W-3:0], 2'b00};
        if (acc >= trial)
        begin
            cell_next.rem  = acc - trial;
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = acc;
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- rtl/ibw_div_cell.sv -----
// ---------------------------------------------------------------------------
// ibw_div_cell
// One quotient bit of the restoring fraction divider.
// ---------------------------------------------------------------------------
module ibw_div_cell
    import ibw_pkg::*;
    (
    input  logic      clk,
    input  logic      en,
    input  div_cell_t cell_in,
    output div_cell_t cell_out
    );

    logic [DIVM_W:0] diff;
    logic            bit_q;
    div_cell_t       cell_next;
    div_cell_t       cell_reg;

    // compare and subtract, then shift the partial remainder
    always_comb
    begin
        bit_q = (cell_in.rem >= {1'b0, cell_in.den});
        diff  = bit_q ? (cell_in.rem - {1'b0, cell_in.den}) : cell_in.rem;
        cell_next     = cell_in;
        cell_next.rem = {diff[DIVM_W-1:0], 1'b0};
        cell_next.q   = {cell_in.q[Q_W-2:0], bit_q};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- rtl/ibw_frac_div.sv -----
// ---------------------------------------------------------------------------
// ibw_frac_div
// Pipelined trunc(num * 2^F / den) with range check 0..2^F.
// ---------------------------------------------------------------------------
module ibw_frac_div
    import ibw_pkg::*;
    (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [DIV_W-1:0] num,
    input  logic signed [DIV_W-1:0] den,
    output logic [Q_W-1:0]          q,
    output logic                    ok
    );

    logic [DIVM_W-1:0] num_mag;
    logic [DIVM_W-1:0] den_mag;
    div_cell_t         prep_next;
    div_cell_t         link [DIV_CELLS+1];
    logic [Q_W-1:0]    q_reg;
    logic              ok_reg;
    logic              ok_next;

    // magnitudes, sign and integer part check (quotient below two)
    always_comb
    begin
        num_mag = num[DIV_W-1] ? DIVM_W'(-num) : DIVM_W'(num);
        den_mag = den[DIV_W-1] ? DIVM_W'(-den) : DIVM_W'(den);
        prep_next.rem = {1'b0, num_mag};
        prep_next.den = den_mag;
        prep_next.q   = '0;
        prep_next.neg = num[DIV_W-1] ^ den[DIV_W-1];
        prep_next.ok  = (den_mag != '0) && ({1'b0, num_mag} < {den_mag, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            link[0] <= prep_next;
        end
    end

    // chain of quotient cells
    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_cell
        ibw_div_cell u_cell
            (
            .clk      (clk),
            .en       (en),
            .cell_in  (link[k]),
            .cell_out (link[k+1])
            );
    end

    // final range check
    assign ok_next = link[DIV_CELLS].ok && (link[DIV_CELLS].q <= ONE_Q) &&
                     (!link[DIV_CELLS].neg || (link[DIV_CELLS].q == '0));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg  <= link[DIV_CELLS].q;
            ok_reg <= ok_next;
        end
    end

    assign q  = q_reg;
    assign ok = ok_reg;

endmodule

// ----- rtl/inverse_bilinear_weights.sv -----
// ---------------------------------------------------------------------------
// inverse_bilinear_weights
// Solves the inverse bilinear map of a point against four configured
// corners and returns four corner weights and an inside flag.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one point per beat, m_axis one result per beat.
//   Corners are written over the APB port (byte address 4*i) while idle.
//   s_axis_tdata : [15:0] point_x, [31:16] point_y (signed Q12.4)
//   m_axis_tdata : [15:0] weight_00, [31:16] weight_01, [47:32] weight_10,
//                  [63:48] weight_11 (unsigned Q1.15)
//   m_axis_tuser : [0] inside_res
// Throughput: one point per clock, sustained while s_axis_tready is high.
// Most of the pipeline depth lies in the 32-cell square root chain and
//   the two 18-stage divider chains.
// Reset clears the corners to zero and empties the pipeline; no
//   clearing pass is needed.
// A stalled receiver parks one result in the output register and one in
//   a skid register; only then does s_axis_tready drop and the whole
//   pipeline hold.
// ---------------------------------------------------------------------------
module inverse_bilinear_weights
    import ibw_pkg::*;
    (
    input  logic              clk,
    input  logic              rst_n,
    // point_x [15:0], point_y [31:16]
    input  logic [31:0]       s_axis_tdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // weight_00 [15:0], weight_01 [31:16], weight_10 [47:32], weight_11 [63:48]
    output logic [63:0]       m_axis_tdata,
    // inside_res [0]
    output logic [0:0]        m_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
    );

    // configuration registers
    logic signed [COORD_W-1:0] c00x_reg, c00y_reg, c01x_reg, c01y_reg;
    logic signed [COORD_W-1:0] c10x_reg, c10y_reg, c11x_reg, c11y_reg;
    logic [CFG_IW-1:0]         cfg_idx;
    logic                      cfg_wr;
    logic [COORD_W-1:0]        rd_val;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c00x_reg <= '0; c00y_reg <= '0; c01x_reg <= '0; c01y_reg <= '0;
            c10x_reg <= '0; c10y_reg <= '0; c11x_reg <= '0; c11y_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_C00X: c00x_reg <= pwdata[COORD_W-1:0];
                REG_C00Y: c00y_reg <= pwdata[COORD_W-1:0];
                REG_C01X: c01x_reg <= pwdata[COORD_W-1:0];
                REG_C01Y: c01y_reg <= pwdata[COORD_W-1:0];
                REG_C10X: c10x_reg <= pwdata[COORD_W-1:0];
                REG_C10Y: c10y_reg <= pwdata[COORD_W-1:0];
                REG_C11X: c11x_reg <= pwdata[COORD_W-1:0];
                REG_C11Y: c11y_reg <= pwdata[COORD_W-1:0];
                default:  ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (cfg_idx)
            REG_C00X: rd_val = c00x_reg;
            REG_C00Y: rd_val = c00y_reg;
            REG_C01X: rd_val = c01x_reg;
            REG_C01Y: rd_val = c01y_reg;
            REG_C10X: rd_val = c10x_reg;
            REG_C10Y: rd_val = c10y_reg;
            REG_C11X: rd_val = c11x_reg;
            REG_C11Y: rd_val = c11y_reg;
            default:  rd_val = '0;
        endcase
    end

    assign prdata = {{(32-COORD_W){1'b0}}, rd_val};

    // corner differences, static between writes
    logic signed [D2_W-1:0] ax, ay;
    logic signed [D1_W-1:0] bx, by, cx, cy;

    assign ax = D2_W'(c00x_reg) - D2_W'(c01x_reg) - D2_W'(c10x_reg) + D2_W'(c11x_reg);
    assign ay = D2_W'(c00y_reg) - D2_W'(c01y_reg) - D2_W'(c10y_reg) + D2_W'(c11y_reg);
    assign bx = D1_W'(c01x_reg) - D1_W'(c00x_reg);
    assign by = D1_W'(c01y_reg) - D1_W'(c00y_reg);
    assign cx = D1_W'(c10x_reg) - D1_W'(c00x_reg);
    assign cy = D1_W'(c10y_reg) - D1_W'(c00y_reg);

    // pipeline advance and valid chain
    logic              en;
    logic [ST_W:1]     vld_reg;
    logic              skid_vld_reg;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ST_W-1:1], s_axis_tvalid};
        end
    end

    // stage 1: point differences
    logic signed [COORD_W-1:0] px, py;
    logic signed [D1_W-1:0]    dx3_next, dy3_next, dx3_reg, dy3_reg;

    assign px       = s_axis_tdata[COORD_W-1:0];
    assign py       = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign dx3_next = D1_W'(c00x_reg) - D1_W'(px);
    assign dy3_next = D1_W'(c00y_reg) - D1_W'(py);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx3_reg <= dx3_next;
            dy3_reg <= dy3_next;
        end
    end

    // stage 2: coefficient products
    logic signed [PROD_W-1:0] pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [PROD_W-1:0] pb2_reg, pb3_reg, pc0_reg, pc1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa0_reg <= ay * bx;
            pa1_reg <= by * ax;
            pb0_reg <= ay * dx3_reg;
            pb1_reg <= cy * bx;
            pb2_reg <= dy3_reg * ax;
            pb3_reg <= by * cx;
            pc0_reg <= cy * dx3_reg;
            pc1_reg <= dy3_reg * cx;
        end
    end

    // stage 3: quadratic coefficients
    logic signed [COEF_W-1:0] ca_reg, cb_reg, cc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ca_reg <= COEF_W'(pa1_reg) - COEF_W'(pa0_reg);
            cb_reg <= COEF_W'(pb2_reg) + COEF_W'(pb3_reg) - COEF_W'(pb0_reg)
                      - COEF_W'(pb1_reg);
            cc_reg <= COEF_W'(pc1_reg) - COEF_W'(pc0_reg);
        end
    end

    // stage 4: magnitudes and signs
    logic [MAG_W-1:0] am_reg, bm_reg, cm_reg;
    logic             as_reg, bs_reg, cs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am_reg <= ca_reg[COEF_W-1] ? MAG_W'(-ca_reg) : MAG_W'(ca_reg);
            bm_reg <= cb_reg[COEF_W-1] ? MAG_W'(-cb_reg) : MAG_W'(cb_reg);
            cm_reg <= cc_reg[COEF_W-1] ? MAG_W'(-cc_reg) : MAG_W'(cc_reg);
            as_reg <= ca_reg[COEF_W-1];
            bs_reg <= cb_reg[COEF_W-1];
            cs_reg <= cc_reg[COEF_W-1];
        end
    end

    // stage 5: common scale down, truncating toward zero
    logic [MAG_W-1:0]         or_mag;
    logic [SH_W-1:0]          sh;
    logic [NMAG_W-1:0]        an_m, bn_m, cn_m;
    logic signed [NORM_W-1:0] an_next, bn_next, cn_next;
    logic signed [NORM_W-1:0] an_reg, bn_reg, cn_reg;

    always_comb
    begin
        or_mag = am_reg | bm_reg | cm_reg;
        sh     = '0;
        for (int i = NMAG_W; i < MAG_W; i++)
        begin
            if (or_mag[i])
            begin
                sh = SH_W'(i - NMAG_W + 1);
            end
        end
        an_m    = NMAG_W'(am_reg >> sh);
        bn_m    = NMAG_W'(bm_reg >> sh);
        cn_m    = NMAG_W'(cm_reg >> sh);
        an_next = as_reg ? -NORM_W'(an_m) : NORM_W'(an_m);
        bn_next = bs_reg ? -NORM_W'(bn_m) : NORM_W'(bn_m);
        cn_next = cs_reg ? -NORM_W'(cn_m) : NORM_W'(cn_m);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg <= an_next;
            bn_reg <= bn_next;
            cn_reg <= cn_next;
        end
    end

    // stage 6: discriminant products
    logic signed [SQP_W-1:0] bb_reg, ac_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg <= bn_reg * bn_reg;
            ac_reg <= an_reg * cn_reg;
        end
    end

    // stage 7: discriminant
    logic signed [DISC_W-1:0] disc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_reg <= DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
        end
    end

    // square root chain
    sqrt_cell_t sq_link [SQRT_STEPS+1];

    assign sq_link[0].rad  = disc_reg;
    assign sq_link[0].rem  = '0;
    assign sq_link[0].root = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        ibw_sqrt_cell u_sqrt
            (
            .clk      (clk),
            .en       (en),
            .cell_in  (sq_link[k]),
            .cell_out (sq_link[k+1])
            );
    end

    // coefficients and sign of discriminant alongside the root chain
    logic signed [NORM_W-1:0] an_d, bn_d, cn_d;
    logic                     dneg_d;

    ibw_delay #(.WIDTH(3*NORM_W), .DEPTH(ST_SQ - ST_NORM)) u_dly_coef
        (
        .clk  (clk),
        .en   (en),
        .din  ({an_reg, bn_reg, cn_reg}),
        .dout ({an_d, bn_d, cn_d})
        );

    ibw_delay #(.WIDTH(1), .DEPTH(ST_SQ - ST_DISC)) u_dly_dneg
        (
        .clk  (clk),
        .en   (en),
        .din  (disc_reg[DISC_W-1]),
        .dout (dneg_d)
        );

    // u numerators and divisors, quadratic or linear
    logic signed [DIV_W-1:0] sq_ext, bnx, anx;
    logic signed [DIV_W-1:0] un1_next, ud1_next, un2_next, ud2_next;
    logic signed [DIV_W-1:0] un1_reg, ud1_reg, un2_reg, ud2_reg;

    always_comb
    begin
        sq_ext = DIV_W'(sq_link[SQRT_STEPS].root);
        bnx    = DIV_W'(bn_d);
        anx    = DIV_W'(an_d);
        if (an_d != '0)
        begin
            un1_next = sq_ext - bnx;
            un2_next = -bnx - sq_ext;
            ud1_next = dneg_d ? '0 : (anx <<< 1);
            ud2_next = ud1_next;
        end
        else
        begin
            un1_next = -DIV_W'(cn_d);
            ud1_next = dneg_d ? '0 : bnx;
            un2_next = '0;
            ud2_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un1_reg <= un1_next;
            ud1_reg <= ud1_next;
            un2_reg <= un2_next;
            ud2_reg <= ud2_next;
        end
    end

    // u dividers
    logic [Q_W-1:0] tu1, tu2;
    logic           uok1, uok2;

    ibw_frac_div u_div_u1
        (.clk(clk), .en(en), .num(un1_reg), .den(ud1_reg), .q(tu1), .ok(uok1));
    ibw_frac_div u_div_u2
        (.clk(clk), .en(en), .num(un2_reg), .den(ud2_reg), .q(tu2), .ok(uok2));

    // point differences alongside, up to the v stage
    logic signed [D1_W-1:0] dx3_d, dy3_d;

    ibw_delay #(.WIDTH(2*D1_W), .DEPTH(ST_VPROD - ST_D)) u_dly_pt
        (
        .clk  (clk),
        .en   (en),
        .din  ({dx3_reg, dy3_reg}),
        .dout ({dx3_d, dy3_d})
        );

    // v products for both u candidates
    logic signed [Q_W:0]     ux1, ux2;
    logic signed [VP_W-1:0]  yb1_reg, ya1_reg, xb1_reg, xa1_reg;
    logic signed [VP_W-1:0]  yb2_reg, ya2_reg, xb2_reg, xa2_reg;
    logic                    uok1_reg, uok2_reg;

    assign ux1 = {1'b0, tu1};
    assign ux2 = {1'b0, tu2};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yb1_reg  <= by * ux1;
            ya1_reg  <= ay * ux1;
            xb1_reg  <= bx * ux1;
            xa1_reg  <= ax * ux1;
            yb2_reg  <= by * ux2;
            ya2_reg  <= ay * ux2;
            xb2_reg  <= bx * ux2;
            xa2_reg  <= ax * ux2;
            uok1_reg <= uok1;
            uok2_reg <= uok2;
        end
    end

    // v numerators and divisors, y relation and x relation
    logic signed [DIV_W-1:0] dy_s, dx_s, cy_s, cx_s;
    logic signed [DIV_W-1:0] vny1_reg, vdy1_reg, vnx1_reg, vdx1_reg;
    logic signed [DIV_W-1:0] vny2_reg, vdy2_reg, vnx2_reg, vdx2_reg;

    assign dy_s = DIV_W'(dy3_d) <<< FRAC;
    assign dx_s = DIV_W'(dx3_d) <<< FRAC;
    assign cy_s = DIV_W'(cy) <<< FRAC;
    assign cx_s = DIV_W'(cx) <<< FRAC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vny1_reg <= -(DIV_W'(yb1_reg) + dy_s);
            vdy1_reg <= uok1_reg ? DIV_W'(ya1_reg) + cy_s : '0;
            vnx1_reg <= -(DIV_W'(xb1_reg) + dx_s);
            vdx1_reg <= uok1_reg ? DIV_W'(xa1_reg) + cx_s : '0;
            vny2_reg <= -(DIV_W'(yb2_reg) + dy_s);
            vdy2_reg <= uok2_reg ? DIV_W'(ya2_reg) + cy_s : '0;
            vnx2_reg <= -(DIV_W'(xb2_reg) + dx_s);
            vdx2_reg <= uok2_reg ? DIV_W'(xa2_reg) + cx_s : '0;
        end
    end

    // v dividers
    logic [Q_W-1:0] vy1, vx1, vy2, vx2;
    logic           oky1, okx1, oky2, okx2;

    ibw_frac_div u_div_vy1
        (.clk(clk), .en(en), .num(vny1_reg), .den(vdy1_reg), .q(vy1), .ok(oky1));
    ibw_frac_div u_div_vx1
        (.clk(clk), .en(en), .num(vnx1_reg), .den(vdx1_reg), .q(vx1), .ok(okx1));
    ibw_frac_div u_div_vy2
        (.clk(clk), .en(en), .num(vny2_reg), .den(vdy2_reg), .q(vy2), .ok(oky2));
    ibw_frac_div u_div_vx2
        (.clk(clk), .en(en), .num(vnx2_reg), .den(vdx2_reg), .q(vx2), .ok(okx2));

    // u candidates alongside the v dividers
    logic [Q_W-1:0] tu1_d, tu2_d;

    ibw_delay #(.WIDTH(2*Q_W), .DEPTH(ST_V - ST_U)) u_dly_u
        (
        .clk  (clk),
        .en   (en),
        .din  ({tu1, tu2}),
        .dout ({tu1_d, tu2_d})
        );

    // pair selection, second root wins
    logic           pair1, pair2;
    logic [Q_W-1:0] u_reg, v_reg;
    logic           found_reg;

    assign pair1 = oky1 || okx1;
    assign pair2 = oky2 || okx2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg <= pair1 || pair2;
            if (pair2)
            begin
                u_reg <= tu2_d;
                v_reg <= oky2 ? vy2 : vx2;
            end
            else
            begin
                u_reg <= tu1_d;
                v_reg <= oky1 ? vy1 : vx1;
            end
        end
    end

    // corner weights with rounding
    logic [Q_W-1:0]  omu, omv;
    logic [WP_W-1:0] p00, p01, p10, p11;
    logic [W_W-1:0]  w00_reg, w01_reg, w10_reg, w11_reg;
    logic            inside_reg;

    assign omu = ONE_Q - u_reg;
    assign omv = ONE_Q - v_reg;
    assign p00 = omu * omv + HALF_Q;
    assign p01 = u_reg * omv + HALF_Q;
    assign p10 = omu * v_reg + HALF_Q;
    assign p11 = u_reg * v_reg + HALF_Q;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= found_reg;
            w00_reg    <= found_reg ? p00[FRAC +: W_W] : '0;
            w01_reg    <= found_reg ? p01[FRAC +: W_W] : '0;
            w10_reg    <= found_reg ? p10[FRAC +: W_W] : '0;
            w11_reg    <= found_reg ? p11[FRAC +: W_W] : '0;
        end
    end

    // output register and skid register
    logic [63:0] pipe_data, skid_data_reg, m_data_reg;
    logic        skid_user_reg, m_user_reg, m_vld_reg;
    logic        out_free;

    assign pipe_data = {w11_reg, w10_reg, w01_reg, w00_reg};
    assign out_free  = !m_vld_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_vld_reg    <= skid_vld_reg || vld_reg[ST_W];
            skid_vld_reg <= 1'b0;
        end
        else if (en && vld_reg[ST_W])
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            m_data_reg <= skid_vld_reg ? skid_data_reg : pipe_data;
            m_user_reg <= skid_vld_reg ? skid_user_reg : inside_reg;
        end
        else if (en)
        begin
            skid_data_reg <= pipe_data;
            skid_user_reg <= inside_reg;
        end
    end

    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tvalid = m_vld_reg;

    // checks
    logic [W_W+1:0] wsum;

    assign wsum = (W_W+2)'(m_data_reg[15:0]) + (W_W+2)'(m_data_reg[31:16])
                + (W_W+2)'(m_data_reg[47:32]) + (W_W+2)'(m_data_reg[63:48]);

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> m_vld_reg)
        else $error("skid register holds a beat while output is empty");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_vld_reg && !m_user_reg) |-> (m_data_reg == '0))
        else $error("weights not zero for a point outside");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (m_vld_reg && m_user_reg) |->
        ((wsum >= (W_W+2)'(ONE_Q) - 2) && (wsum <= (W_W+2)'(ONE_Q) + 2)))
        else $error("weights do not sum to one");

endmodule
